// File: rtl/core/lce_pkg.sv
package lce_pkg;

	typedef enum logic [4:0] {
		OP_HOLD = 5'd0,
		OP_COPY = 5'd1,
		OP_OR   = 5'd2,
		OP_XOR  = 5'd3,
		OP_NOT  = 5'd4,
		OP_AND  = 5'd5,
		OP_SHL  = 5'd6,
		OP_SHR  = 5'd7,
		OP_ADD  = 5'd8,
		OP_SUB  = 5'd9,
		OP_MUL  = 5'd10,
		OP_DIV  = 5'd11,
		OP_GT   = 5'd12,
		OP_LT   = 5'd13,
		OP_EQ   = 5'd14,
		OP_GE   = 5'd15,
		OP_LE   = 5'd16
	} op_t;

	localparam int unsigned OP_BITS = 5;

endpackage

// File: rtl/core/lce_front.sv
// First stage: every operation except divide is finished here. Multiply is a
// single DATA_WIDTH x DATA_WIDTH product that keeps the low half.
module lce_front #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic [lce_pkg::OP_BITS-1:0] operation,
	input  logic [DATA_WIDTH-1:0]       operand_a,
	input  logic [DATA_WIDTH-1:0]       operand_b,
	input  logic [DATA_WIDTH-1:0]       previous_output,
	output logic [DATA_WIDTH-1:0]       value,
	output logic                        is_div
);
	localparam int unsigned SW = $clog2(DATA_WIDTH);

	logic big_shift;
	logic gt;
	logic eq;

	assign big_shift = operand_b > DATA_WIDTH'(DATA_WIDTH - 1);
	assign gt = operand_a > operand_b;
	assign eq = operand_a == operand_b;
	assign is_div = operation == lce_pkg::OP_DIV;

	always_comb begin
		case (operation)
			lce_pkg::OP_COPY: value = operand_a;
			lce_pkg::OP_OR:   value = operand_a | operand_b;
			lce_pkg::OP_XOR:  value = operand_a ^ operand_b;
			lce_pkg::OP_NOT:  value = ~operand_a;
			lce_pkg::OP_AND:  value = operand_a & operand_b;
			lce_pkg::OP_SHL:  value = big_shift ? '0 : operand_a << operand_b[SW-1:0];
			lce_pkg::OP_SHR:  value = big_shift ? '0 : operand_a >> operand_b[SW-1:0];
			lce_pkg::OP_ADD:  value = operand_a + operand_b;
			lce_pkg::OP_SUB:  value = operand_a - operand_b;
			lce_pkg::OP_MUL:  value = operand_a * operand_b;
			lce_pkg::OP_GT:   value = {DATA_WIDTH{gt}};
			lce_pkg::OP_LT:   value = {DATA_WIDTH{!gt && !eq}};
			lce_pkg::OP_EQ:   value = {DATA_WIDTH{eq}};
			lce_pkg::OP_GE:   value = {DATA_WIDTH{gt || eq}};
			lce_pkg::OP_LE:   value = {DATA_WIDTH{!gt}};
			default:          value = previous_output;
		endcase
	end
endmodule

// File: rtl/core/lce_div_cell.sv
// One restoring-division step. Each cell forms one quotient bit, most
// significant first, and passes remainder and partial quotient to the next.
module lce_div_cell #(
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned BIT_POS    = 0
) (
	input  logic                  clk,
	input  logic [DATA_WIDTH-1:0] rem_in,
	input  logic [DATA_WIDTH-1:0] quo_in,
	input  logic [DATA_WIDTH-1:0] div_in,
	input  logic [DATA_WIDTH-1:0] num_in,
	output logic [DATA_WIDTH-1:0] rem_s1,
	output logic [DATA_WIDTH-1:0] quo_s1,
	output logic [DATA_WIDTH-1:0] div_s1,
	output logic [DATA_WIDTH-1:0] num_s1
);
	logic [DATA_WIDTH:0] trial;
	logic                take;

	assign trial = {rem_in, num_in[BIT_POS]};
	assign take  = trial >= {1'b0, div_in};

	always_ff @(posedge clk) begin
		rem_s1 <= take ? DATA_WIDTH'(trial - {1'b0, div_in}) : trial[DATA_WIDTH-1:0];
		quo_s1 <= quo_in | (DATA_WIDTH'(take) << BIT_POS);
		div_s1 <= div_in;
		num_s1 <= num_in;
	end
endmodule

// File: rtl/core/logic_cell_evaluator_top.sv
// Throughput: one item per cycle while the output is taken; the divider is a
// chain of DATA_WIDTH cells, one quotient bit each, and all operations travel
// through it in lockstep. Reset (arst_n low, asynchronous) empties the
// pipeline; no items are lost while out_ready is low because the whole chain
// stalls.
module logic_cell_evaluator_top #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [lce_pkg::OP_BITS-1:0] operation,
	input  logic [DATA_WIDTH-1:0]       operand_a,
	input  logic [DATA_WIDTH-1:0]       operand_b,
	input  logic [DATA_WIDTH-1:0]       previous_output,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [DATA_WIDTH-1:0]       result,
	output logic                        changed
);
	localparam int unsigned N = DATA_WIDTH;

	logic [DATA_WIDTH-1:0] fv;
	logic                  fdiv;
	logic                  adv;

	// Stage registers after the front end; the cell chain follows.
	logic [N:0]            vld_q;
	logic [DATA_WIDTH-1:0] val_q  [N+1];
	logic [DATA_WIDTH-1:0] prev_q [N+1];
	logic                  isd_q  [N+1];
	logic [DATA_WIDTH-1:0] rem [N+1];
	logic [DATA_WIDTH-1:0] quo [N+1];
	logic [DATA_WIDTH-1:0] dv  [N+1];
	logic [DATA_WIDTH-1:0] nm  [N+1];
	logic [DATA_WIDTH-1:0] b_s1;
	logic [DATA_WIDTH-1:0] a_s1;

	// The chain advances unless the last slot holds an item not yet taken.
	assign adv      = !vld_q[N] || out_ready;
	assign in_ready = adv;

	lce_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.operation(operation), .operand_a(operand_a), .operand_b(operand_b),
		.previous_output(previous_output), .value(fv), .is_div(fdiv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[N-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			val_q[0]  <= fv;
			prev_q[0] <= previous_output;
			isd_q[0]  <= fdiv;
			a_s1      <= operand_a;
			b_s1      <= (operand_b == '0) ? DATA_WIDTH'(1) : operand_b;
			for (int i = 1; i <= N; i++) begin
				val_q[i]  <= val_q[i-1];
				prev_q[i] <= prev_q[i-1];
				isd_q[i]  <= isd_q[i-1];
			end
		end
	end

	assign rem[0] = '0;
	assign quo[0] = '0;
	assign dv[0]  = b_s1;
	assign nm[0]  = a_s1;

	for (genvar g = 0; g < N; g++) begin : g_cell
		logic [DATA_WIDTH-1:0] r_o, q_o, d_o, n_o;
		logic [DATA_WIDTH-1:0] r_h, q_h, d_h, n_h;
		lce_div_cell #(.DATA_WIDTH(DATA_WIDTH), .BIT_POS(N-1-g)) u_cell (
			.clk(clk), .rem_in(adv ? rem[g] : r_h), .quo_in(adv ? quo[g] : q_h),
			.div_in(adv ? dv[g] : d_h), .num_in(adv ? nm[g] : n_h),
			.rem_s1(r_o), .quo_s1(q_o), .div_s1(d_o), .num_s1(n_o)
		);
		// On a stall the cell recomputes from a held copy of its own input.
		always_ff @(posedge clk) begin
			if (adv) begin
				r_h <= rem[g];
				q_h <= quo[g];
				d_h <= dv[g];
				n_h <= nm[g];
			end
		end
		assign rem[g+1] = r_o;
		assign quo[g+1] = q_o;
		assign dv[g+1]  = d_o;
		assign nm[g+1]  = n_o;
	end

	assign out_valid = vld_q[N];
	assign result    = isd_q[N] ? quo[N] : val_q[N];
	assign changed   = result != prev_q[N];
endmodule

// File: rtl/core/lce_checker.sv
module lce_checker #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [DATA_WIDTH-1:0] result,
	input logic                  changed
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result) && $stable(changed))
		else $error("output item dropped or changed while stalled");
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("input taken while pipeline stalled");
	a_rst: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");
endmodule

bind logic_cell_evaluator_top lce_checker #(.DATA_WIDTH(DATA_WIDTH)) u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .result(result), .changed(changed)
);

// File: tb/sv/lce_checker.sv
`timescale 1ns / 1ps

module lce_scoreboard #(
	parameter int unsigned DATA_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [lce_pkg::OP_BITS-1:0] operation,
	input  logic [DATA_WIDTH-1:0]       operand_a,
	input  logic [DATA_WIDTH-1:0]       operand_b,
	input  logic [DATA_WIDTH-1:0]       previous_output,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [DATA_WIDTH-1:0]       result,
	input  logic                        changed,
	output int                          fail_count,
	output int                          pending
);
	typedef struct packed {
		logic [DATA_WIDTH-1:0] value;
		logic                  changed;
	} cell_out_t;

	cell_out_t expected_outputs[$];
	int fails = 0;
	int depth = 0;

	function automatic cell_out_t eval_cell(logic [lce_pkg::OP_BITS-1:0] code,
			logic [DATA_WIDTH-1:0] a, logic [DATA_WIDTH-1:0] b,
			logic [DATA_WIDTH-1:0] prev);
		logic [DATA_WIDTH-1:0] ones;
		logic [DATA_WIDTH-1:0] r;
		cell_out_t o;
		ones = '1;
		case (code)
			lce_pkg::OP_COPY: r = a;
			lce_pkg::OP_OR:   r = a | b;
			lce_pkg::OP_XOR:  r = a ^ b;
			lce_pkg::OP_NOT:  r = ~a;
			lce_pkg::OP_AND:  r = a & b;
			lce_pkg::OP_SHL:  r = (b >= DATA_WIDTH) ? '0 : a << b;
			lce_pkg::OP_SHR:  r = (b >= DATA_WIDTH) ? '0 : a >> b;
			lce_pkg::OP_ADD:  r = a + b;
			lce_pkg::OP_SUB:  r = a - b;
			lce_pkg::OP_MUL:  r = a * b;
			lce_pkg::OP_DIV:  r = a / ((b == '0) ? DATA_WIDTH'(1) : b);
			lce_pkg::OP_GT:   r = (a > b) ? ones : '0;
			lce_pkg::OP_LT:   r = (a < b) ? ones : '0;
			lce_pkg::OP_EQ:   r = (a == b) ? ones : '0;
			lce_pkg::OP_GE:   r = (a >= b) ? ones : '0;
			lce_pkg::OP_LE:   r = (a <= b) ? ones : '0;
			default:          r = prev;
		endcase
		o.value = r;
		o.changed = (r != prev);
		return o;
	endfunction

	assign fail_count = fails;
	assign pending = depth;

	always @(posedge clk) begin
		cell_out_t want;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_outputs = {expected_outputs, eval_cell(operation, operand_a,
					operand_b, previous_output)};
			if (out_valid && out_ready) begin
				if (expected_outputs.size() == 0) begin
					$display("%0t: unexpected result %h changed %b", $time, result, changed);
					fails <= fails + 1;
				end else begin
					want = expected_outputs.pop_front();
					if (want.value !== result || want.changed !== changed) begin
						$display("%0t: mismatch expected %h/%b actual %h/%b", $time,
							want.value, want.changed, result, changed);
						fails <= fails + 1;
					end
				end
			end
			depth <= expected_outputs.size();
		end
	end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
	localparam int unsigned W = 32;
	localparam int unsigned OPW = lce_pkg::OP_BITS;
	// Codes outside the defined kinds act as hold.
	localparam logic [OPW-1:0] OP_UNUSED_LO = OPW'(17);
	localparam logic [OPW-1:0] OP_UNUSED_HI = OPW'(31);

	logic clk = 0;
	logic arst_n;
	logic in_valid = 0;
	logic in_ready;
	logic [OPW-1:0] operation = '0;
	logic [W-1:0] operand_a = '0;
	logic [W-1:0] operand_b = '0;
	logic [W-1:0] previous_output = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [W-1:0] result;
	logic changed;
	int fail_count;
	int pending;
	int send_idle_pct = 17;
	int recv_idle_pct = 47;
	bit long_stall = 0;

	always #1 clk = ~clk;

	logic_cell_evaluator_top #(.DATA_WIDTH(W)) i_dut (.*);

	lce_scoreboard #(.DATA_WIDTH(W)) i_checker (.*);

	function automatic logic [W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return $urandom_range(0, 40);
			3: return 32'h8000_0000 >> $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_cell(logic [OPW-1:0] code, logic [W-1:0] a, logic [W-1:0] b,
			logic [W-1:0] prev);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		operation <= code;
		operand_a <= a;
		operand_b <= b;
		previous_output <= prev;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_random(int count);
		logic [W-1:0] r;
		logic [W-1:0] a;
		for (int i = 0; i < count; i++) begin
			a = pick_value();
			r = pick_value();
			// Previous output often equals operand a so that the changed flag clears.
			send_cell(OPW'($urandom_range(0, 99) < 90
				? $urandom_range(lce_pkg::OP_HOLD, lce_pkg::OP_LE)
				: $urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), a,
				$urandom_range(0, 3) == 0 ? a : pick_value(),
				$urandom_range(0, 3) == 0 ? a : r);
		end
	endtask

	always @(negedge clk) begin
		if (long_stall)
			out_ready <= 0;
		else
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	initial begin
		#200000;
		$display("FAIL");
		$finish;
	end

	initial begin
		arst_n <= 0;
		repeat (4) @(negedge clk);
		arst_n <= 1;
		@(negedge clk);
		send_cell(lce_pkg::OP_HOLD, '1, '1, 32'h1234_5678);
		send_cell(lce_pkg::OP_COPY, '1, '0, '0);
		send_cell(lce_pkg::OP_OR, 32'hF0F0_0000, 32'h0000_0F0F, '0);
		send_cell(lce_pkg::OP_XOR, '1, 32'hAAAA_AAAA, '0);
		send_cell(lce_pkg::OP_NOT, '0, '0, '1);
		send_cell(lce_pkg::OP_AND, '1, 32'h5555_5555, '0);
		send_cell(lce_pkg::OP_SHL, '1, 31, '0);
		send_cell(lce_pkg::OP_SHL, '1, 32, '1);
		send_cell(lce_pkg::OP_SHR, '1, 31, '0);
		send_cell(lce_pkg::OP_SHR, '1, '1, '0);
		send_cell(lce_pkg::OP_ADD, '1, 1, '1);
		send_cell(lce_pkg::OP_SUB, '0, 1, '0);
		send_cell(lce_pkg::OP_MUL, '1, '1, '0);
		send_cell(lce_pkg::OP_DIV, '1, '0, '0);
		send_cell(lce_pkg::OP_DIV, 100, 7, '0);
		send_cell(lce_pkg::OP_DIV, 5, '1, '0);
		send_cell(lce_pkg::OP_GT, '1, '0, '0);
		send_cell(lce_pkg::OP_LT, '1, '0, '0);
		send_cell(lce_pkg::OP_EQ, 7, 7, '1);
		send_cell(lce_pkg::OP_GE, 3, 3, '0);
		send_cell(lce_pkg::OP_LE, 4, 3, '0);
		send_cell(OP_UNUSED_HI, 1, 2, 32'hDEAD_BEEF);
		send_cell(OP_UNUSED_LO, 1, 2, '0);
		send_random(540);
		send_idle_pct = 47;
		recv_idle_pct = 17;
		send_random(560);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		fork
			begin
				long_stall = 1;
				repeat (150) @(negedge clk);
				long_stall = 0;
			end
			send_random(580);
		join
		in_valid <= 0;
		while (pending != 0)
			@(negedge clk);
		repeat (50) @(negedge clk);
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
